/* hw/rtl/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the battery charge supervisor
// relay phase and action codes, register indexes, reset values and widths
// ----------------------------------------------------------------------------
package bcs_pkg;

   // default widths
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int COUNT_BITS_DEF  = 16;

   // fixed widths of the register port and of the dwell limit
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DWELL_BITS     = 16;

   // reset values of the registers
   localparam int RST_SUPPLY_LOW   = 1600;
   localparam int RST_BAT_STOP     = 2570;
   localparam int RST_BAT_UPPER    = 2420;
   localparam int RST_BAT_RECHARGE = 2110;
   localparam int RST_DWELL_TICKS  = 3000;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SUPPLY_LOW   = 3'd0,
      CSR_BAT_STOP     = 3'd1,
      CSR_BAT_UPPER    = 3'd2,
      CSR_BAT_RECHARGE = 3'd3,
      CSR_DWELL_TICKS  = 3'd4
   } csr_index_type;

   // relay sequencer phases
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_CONNECT = 2'd1,
      PH_ONLINE  = 2'd2,
      PH_DISCON  = 2'd3
   } phase_type;

   // relay commands
   typedef enum logic [1:0] {
      ACT_NONE       = 2'd0,
      ACT_CONNECT    = 2'd1,
      ACT_DISCONNECT = 2'd2,
      ACT_RELEASE    = 2'd3
   } action_type;

   // one result, first member in the highest bits
   typedef struct packed {
      logic       online;
      logic       charge_stopped;
      action_type relay_action;
      logic       charger_on;
   } rsp_type;

   localparam int RSP_BITS = 8;

endpackage

/* hw/rtl/battery_charge_supervisor.sv */
// ----------------------------------------------------------------------------
// battery_charge_supervisor: battery relay and charge supervisor
// one scan tick per request transaction, one result transaction per tick
// ----------------------------------------------------------------------------
// usage
//   req channel: one scan tick per transaction, carrying main power, valve
//   state and the supply and battery samples
//   rsp channel: charger enable, relay command, stop latch and online flag
//   csr channel: register writes, always ready; write only while idle
// latency: a tick accepted at one edge is registered at the input, worked
//   through the relay sequencer and charge control in the next cycle and
//   shown on rsp after the following edge, one cycle after acceptance
// throughput: one tick per cycle, set by the single-cycle update of the
//   sequencer and charge state between the input and result registers
// reset: registers return to their defaults, the sequencer goes idle, the
//   stop latch, dwell count and charger level clear, both stages empty
// stall: while rsp_tready is low the result holds, one further tick waits
//   in the input register and req_tready then drops
// ----------------------------------------------------------------------------
module battery_charge_supervisor #(
   parameter int SAMPLE_BITS = bcs_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = bcs_pkg::COUNT_BITS_DEF,
   localparam int REQ_BITS   = ((2 + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // main_power_on, valve_open, supply_sample, battery_sample, zero fill
   input  logic [REQ_BITS-1:0]               req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // charger_on, relay_action, charge_stopped, online, zero fill
   output logic [bcs_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bcs_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int RSP_PAD = bcs_pkg::RSP_BITS - $bits(bcs_pkg::rsp_type);

   logic                          in_valid_ff, in_valid_in;
   logic [2*SAMPLE_BITS+1:0]      in_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   bcs_pkg::rsp_type              rsp_ff;
   bcs_pkg::rsp_type              result;
   logic                          advance;
   logic [SAMPLE_BITS-1:0]        supply_low;
   logic [SAMPLE_BITS-1:0]        bat_stop;
   logic [SAMPLE_BITS-1:0]        bat_upper;
   logic [SAMPLE_BITS-1:0]        bat_recharge;
   logic [bcs_pkg::DWELL_BITS-1:0] dwell_ticks;

   // configuration registers
   bcs_csr #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .supply_low   (supply_low),
      .bat_stop     (bat_stop),
      .bat_upper    (bat_upper),
      .bat_recharge (bat_recharge),
      .dwell_ticks  (dwell_ticks)
   );

   // stage handshake: a tick moves on when the result register is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[2*SAMPLE_BITS+1:0];
      end
   end

   // sequencer and charge control
   bcs_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .power        (in_data_ff[0]),
      .valve        (in_data_ff[1]),
      .supply       (in_data_ff[SAMPLE_BITS+1:2]),
      .battery      (in_data_ff[2*SAMPLE_BITS+1:SAMPLE_BITS+2]),
      .supply_low   (supply_low),
      .bat_stop     (bat_stop),
      .bat_upper    (bat_upper),
      .bat_recharge (bat_recharge),
      .dwell_ticks  (dwell_ticks),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_ff};

endmodule

/* hw/rtl/bcs_csr.sv */
// ----------------------------------------------------------------------------
// bcs_csr: configuration registers
// limits and dwell count written over the register channel
// ----------------------------------------------------------------------------
module bcs_csr #(
   parameter int SAMPLE_BITS = bcs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bcs_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output logic [SAMPLE_BITS-1:0]            supply_low,
   output logic [SAMPLE_BITS-1:0]            bat_stop,
   output logic [SAMPLE_BITS-1:0]            bat_upper,
   output logic [SAMPLE_BITS-1:0]            bat_recharge,
   output logic [bcs_pkg::DWELL_BITS-1:0]     dwell_ticks
);

   logic [SAMPLE_BITS-1:0]        supply_low_ff;
   logic [SAMPLE_BITS-1:0]        bat_stop_ff;
   logic [SAMPLE_BITS-1:0]        bat_upper_ff;
   logic [SAMPLE_BITS-1:0]        bat_recharge_ff;
   logic [bcs_pkg::DWELL_BITS-1:0] dwell_ticks_ff;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_low_ff   <= SAMPLE_BITS'(bcs_pkg::RST_SUPPLY_LOW);
         bat_stop_ff     <= SAMPLE_BITS'(bcs_pkg::RST_BAT_STOP);
         bat_upper_ff    <= SAMPLE_BITS'(bcs_pkg::RST_BAT_UPPER);
         bat_recharge_ff <= SAMPLE_BITS'(bcs_pkg::RST_BAT_RECHARGE);
         dwell_ticks_ff  <= bcs_pkg::DWELL_BITS'(bcs_pkg::RST_DWELL_TICKS);
      end else if (csr_valid) begin
         case (bcs_pkg::csr_index_type'(csr_index))
            bcs_pkg::CSR_SUPPLY_LOW:   supply_low_ff   <= csr_data[SAMPLE_BITS-1:0];
            bcs_pkg::CSR_BAT_STOP:     bat_stop_ff     <= csr_data[SAMPLE_BITS-1:0];
            bcs_pkg::CSR_BAT_UPPER:    bat_upper_ff    <= csr_data[SAMPLE_BITS-1:0];
            bcs_pkg::CSR_BAT_RECHARGE: bat_recharge_ff <= csr_data[SAMPLE_BITS-1:0];
            bcs_pkg::CSR_DWELL_TICKS:  dwell_ticks_ff  <= csr_data[bcs_pkg::DWELL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign supply_low   = supply_low_ff;
   assign bat_stop     = bat_stop_ff;
   assign bat_upper    = bat_upper_ff;
   assign bat_recharge = bat_recharge_ff;
   assign dwell_ticks  = dwell_ticks_ff;

endmodule

/* hw/rtl/bcs_core.sv */
// ----------------------------------------------------------------------------
// bcs_core: relay sequencer and charge control for one scan tick
// state registers and the next-state logic that one tick applies to them
// ----------------------------------------------------------------------------
module bcs_core #(
   parameter int SAMPLE_BITS = bcs_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = bcs_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          power,
   input  logic                          valve,
   input  logic [SAMPLE_BITS-1:0]        supply,
   input  logic [SAMPLE_BITS-1:0]        battery,
   input  logic [SAMPLE_BITS-1:0]        supply_low,
   input  logic [SAMPLE_BITS-1:0]        bat_stop,
   input  logic [SAMPLE_BITS-1:0]        bat_upper,
   input  logic [SAMPLE_BITS-1:0]        bat_recharge,
   input  logic [bcs_pkg::DWELL_BITS-1:0] dwell_ticks,
   output bcs_pkg::rsp_type              result
);

   localparam int CMP_BITS = (COUNT_BITS > bcs_pkg::DWELL_BITS) ? COUNT_BITS
                                                               : bcs_pkg::DWELL_BITS;

   bcs_pkg::phase_type    phase_ff, phase_in;
   logic                  latch_ff, latch_in;
   logic                  level_ff, level_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   bcs_pkg::action_type   action;

   // state registers, advanced once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bcs_pkg::PH_IDLE;
         latch_ff <= 1'b0;
         level_ff <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         latch_ff <= latch_in;
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

   // one tick: sequencer first, then charge management while online
   always_comb begin
      phase_in = phase_ff;
      latch_in = latch_ff;
      level_in = level_ff;
      count_in = count_ff;
      action   = bcs_pkg::ACT_NONE;

      // relay sequencer, first matching rule wins
      if (power && phase_ff == bcs_pkg::PH_IDLE) begin
         phase_in = bcs_pkg::PH_CONNECT;
         action   = bcs_pkg::ACT_CONNECT;
         level_in = 1'b0;
      end else if (phase_ff == bcs_pkg::PH_CONNECT) begin
         phase_in = bcs_pkg::PH_ONLINE;
         action   = bcs_pkg::ACT_RELEASE;
      end else if (!power) begin
         phase_in = bcs_pkg::PH_DISCON;
         action   = bcs_pkg::ACT_DISCONNECT;
         level_in = 1'b0;
      end else if (phase_ff == bcs_pkg::PH_DISCON) begin
         phase_in = bcs_pkg::PH_IDLE;
         action   = bcs_pkg::ACT_RELEASE;
      end

      // charge management
      if (phase_in == bcs_pkg::PH_ONLINE) begin
         if (valve) begin
            level_in = 1'b0;
            latch_in = 1'b1;
         end else if (supply < supply_low) begin
            level_in = 1'b0;
            latch_in = 1'b1;
         end else if (battery > bat_stop) begin
            level_in = 1'b0;
            latch_in = 1'b1;
         end else if (battery < bat_stop && battery > bat_upper && !latch_ff) begin
            // dwell in the top window, saturating count
            if (count_ff != {COUNT_BITS{1'b1}}) begin
               count_in = count_ff + 1'b1;
            end
            if (CMP_BITS'(count_in) > CMP_BITS'(dwell_ticks)) begin
               latch_in = 1'b1;
               level_in = 1'b0;
            end
         end else if (battery < bat_recharge) begin
            if (latch_ff) begin
               latch_in = 1'b0;
               count_in = '0;
            end
            level_in = 1'b1;
         end else begin
            count_in = '0;
         end
      end else begin
         level_in = 1'b0;
      end

      result.charger_on     = level_in;
      result.relay_action   = action;
      result.charge_stopped = latch_in;
      result.online         = (phase_in == bcs_pkg::PH_ONLINE);
   end

endmodule

/* test/tb_battery_charge_supervisor.sv */
// ----------------------------------------------------------------------------
// tb_battery_charge_supervisor: self-checking bench for the charge supervisor
// drives scan ticks and register writes, predicts every result with an
// independent model of the relay sequencer and charge control, and compares
// each result transaction field by field under varied handshake pressure
// ----------------------------------------------------------------------------
module tb_battery_charge_supervisor;
   import bcs_pkg::*;

   localparam int REQ_BITS    = ((2 + 2 * SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 3000000;

   // one scan tick as the bench sees it
   typedef struct packed {
      logic        power;
      logic        valve;
      logic [11:0] supply;
      logic [11:0] battery;
   } tick_type;

   // prediction of the supervisor and queue of outstanding results
   class charge_scoreboard;
      logic [11:0] supply_low;
      logic [11:0] bat_stop;
      logic [11:0] bat_upper;
      logic [11:0] bat_recharge;
      logic [15:0] dwell_limit;
      phase_type   phase;
      logic        latched;
      logic [15:0] dwell_count;
      logic        charging;
      rsp_type     pending_q[$];
      int          errors;

      function new();
         supply_low   = 12'(RST_SUPPLY_LOW);
         bat_stop     = 12'(RST_BAT_STOP);
         bat_upper    = 12'(RST_BAT_UPPER);
         bat_recharge = 12'(RST_BAT_RECHARGE);
         dwell_limit  = 16'(RST_DWELL_TICKS);
         phase        = PH_IDLE;
         latched      = 1'b0;
         dwell_count  = '0;
         charging     = 1'b0;
         errors       = 0;
      endfunction

      // register write accepted by the block
      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_SUPPLY_LOW:   supply_low   = val[11:0];
            CSR_BAT_STOP:     bat_stop     = val[11:0];
            CSR_BAT_UPPER:    bat_upper    = val[11:0];
            CSR_BAT_RECHARGE: bat_recharge = val[11:0];
            CSR_DWELL_TICKS:  dwell_limit  = val;
            default: ;
         endcase
      endfunction

      // accepted tick: step the sequencer, then the charge control
      function void note_tick(tick_type t);
         action_type act;
         rsp_type    r;
         act = ACT_NONE;
         if (t.power && phase == PH_IDLE) begin
            phase    = PH_CONNECT;
            act      = ACT_CONNECT;
            charging = 1'b0;
         end else if (phase == PH_CONNECT) begin
            act   = ACT_RELEASE;
            phase = PH_ONLINE;
         end else if (!t.power) begin
            act      = ACT_DISCONNECT;
            charging = 1'b0;
            phase    = PH_DISCON;
         end else if (phase == PH_DISCON) begin
            act   = ACT_RELEASE;
            phase = PH_IDLE;
         end

         if (phase != PH_ONLINE) begin
            charging = 1'b0;
         end else if (t.valve || t.supply < supply_low || t.battery > bat_stop) begin
            charging = 1'b0;
            latched  = 1'b1;
         end else if (t.battery < bat_stop && t.battery > bat_upper && !latched) begin
            // dwell in the top window, count saturates
            if (dwell_count != '1) dwell_count = dwell_count + 1'b1;
            if (dwell_count > dwell_limit) begin
               latched  = 1'b1;
               charging = 1'b0;
            end
         end else if (t.battery < bat_recharge) begin
            if (latched) begin
               latched     = 1'b0;
               dwell_count = '0;
            end
            charging = 1'b1;
         end else begin
            dwell_count = '0;
         end

         r.online         = (phase == PH_ONLINE);
         r.charge_stopped = latched;
         r.relay_action   = act;
         r.charger_on     = charging;
         pending_q.push_back(r);
      endfunction

      task report(string what, int got, int want);
         if (errors < 100) $display("mismatch %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      // accepted result transaction against the oldest prediction
      task check_result(logic [RSP_BITS-1:0] data);
         rsp_type got;
         rsp_type want;
         got = data[4:0];
         if (data[RSP_BITS-1:5] != '0) report("fill bits", int'(data[RSP_BITS-1:5]), 0);
         if (pending_q.size() == 0) begin
            report("unexpected result", int'(data), 0);
         end else begin
            want = pending_q.pop_front();
            if (got.charger_on != want.charger_on)
               report("charger_on", int'(got.charger_on), int'(want.charger_on));
            if (got.relay_action != want.relay_action)
               report("relay_action", int'(got.relay_action), int'(want.relay_action));
            if (got.charge_stopped != want.charge_stopped)
               report("charge_stopped", int'(got.charge_stopped),
                      int'(want.charge_stopped));
            if (got.online != want.online)
               report("online", int'(got.online), int'(want.online));
         end
      endtask
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   charge_scoreboard sb;
   int unsigned      send_idle  = 0;
   int unsigned      recv_stall = 0;
   int unsigned      cycles     = 0;

   battery_charge_supervisor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: check on handshake, stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   function automatic tick_type mk_tick(logic p, logic v, logic [11:0] s, logic [11:0] b);
      tick_type t;
      t.power   = p;
      t.valve   = v;
      t.supply  = s;
      t.battery = b;
      return t;
   endfunction

   // battery sample aimed at the thresholds of the current setting
   function automatic logic [11:0] pick_battery();
      int unsigned sel;
      int unsigned lo;
      int unsigned hi;
      sel = $urandom_range(99);
      lo  = 0;
      hi  = 4095;
      if (sel < 30) begin
         lo = sb.bat_upper + 1;
         hi = sb.bat_stop - 1;
      end else if (sel < 50) begin
         hi = sb.bat_recharge - 1;
      end else if (sel < 62) begin
         lo = sb.bat_recharge;
         hi = sb.bat_upper;
      end else if (sel < 75) begin
         case ($urandom_range(3))
            0: return sb.bat_stop;
            1: return sb.bat_upper;
            2: return sb.bat_recharge;
            default: return sb.bat_recharge - 1'b1;
         endcase
      end else if (sel < 85) begin
         lo = sb.bat_stop + 1;
      end
      if (hi < lo || hi > 4095) return 12'($urandom_range(4095));
      return 12'($urandom_range(hi, lo));
   endfunction

   task automatic send_tick(tick_type t);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, t.battery, t.supply, t.valve, t.power};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(t);
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   // write all five registers, then one unused index
   task automatic program_regs(input logic [15:0] low_v, stop_v, upper_v, rech_v, dwell_v);
      csr_index_type             idx [5];
      logic [15:0]               vals [5];
      logic [CSR_INDEX_BITS-1:0] ix;
      logic [CSR_DATA_BITS-1:0]  dv;
      settle();
      idx  = '{CSR_SUPPLY_LOW, CSR_BAT_STOP, CSR_BAT_UPPER, CSR_BAT_RECHARGE, CSR_DWELL_TICKS};
      vals = '{low_v, stop_v, upper_v, rech_v, dwell_v};
      for (int i = 0; i < 6; i++) begin
         if (i < 5) begin
            ix = idx[i];
            dv = vals[i];
         end else begin
            ix = CSR_INDEX_BITS'(CSR_DWELL_TICKS + $urandom_range(3, 1));
            dv = CSR_DATA_BITS'($urandom);
         end
         csr_valid <= 1'b1;
         csr_index <= ix;
         csr_data  <= dv;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_reg(ix, dv);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      tick_type    t;
      int unsigned rech;
      int unsigned upper;
      int unsigned stop;
      int unsigned low;
      int unsigned seg_items;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: relay sequence and each charge rule at reset settings
      send_idle  = 20;
      recv_stall = 20;
      send_tick(mk_tick(1'b0, 1'b0, 12'd3000, 12'd1000));   // power off while idle
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd1000));   // release to idle
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd1000));   // connect
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd1000));   // release, online, charge
      send_tick(mk_tick(1'b1, 1'b1, 12'd3000, 12'd1000));   // valve open
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd0));      // recharge clears latch
      send_tick(mk_tick(1'b1, 1'b0, 12'd0, 12'd1000));      // supply low
      send_tick(mk_tick(1'b1, 1'b0, 12'd1599, 12'd0));      // supply one under limit
      send_tick(mk_tick(1'b1, 1'b0, 12'd1600, 12'd0));      // supply at limit
      send_tick(mk_tick(1'b1, 1'b0, 12'd4095, 12'd4095));   // battery over stop level
      send_tick(mk_tick(1'b1, 1'b0, 12'd4095, 12'd2570));   // exactly at stop level
      send_tick(mk_tick(1'b1, 1'b0, 12'd4095, 12'd2109));   // just under recharge
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd2500));   // window, counting
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd2569));   // window top edge
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd2420));   // at upper limit
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd2300));   // between, count cleared
      send_tick(mk_tick(1'b0, 1'b0, 12'd3000, 12'd1000));   // power lost online
      send_tick(mk_tick(1'b0, 1'b1, 12'd3000, 12'd1000));   // disconnect repeats
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd1000));   // release to idle
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd1000));   // connect
      send_tick(mk_tick(1'b0, 1'b0, 12'd3000, 12'd1000));   // connect pulse ignores power
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd1000));   // online again

      // dwell expiry, and the window while latched
      program_regs(16'd1600, 16'd2570, 16'd2420, 16'd2110, 16'd2);
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd0));
      repeat (5) send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd2500));
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd0));
      program_regs(16'd1600, 16'd2570, 16'd2420, 16'd2110, 16'd0);
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd2500));
      send_tick(mk_tick(1'b1, 1'b0, 12'd3000, 12'd0));

      // random segments, two settings per handshake pressure
      for (int seg = 0; seg < 8; seg++) begin
         case (seg / 2)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 86; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 86; end
            default: begin send_idle = 26; recv_stall = 26; end
         endcase
         if (seg == 1) begin
            program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         end else if (seg == 3) begin
            program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         end else if (seg == 5) begin
            program_regs(16'(RST_SUPPLY_LOW), 16'(RST_BAT_STOP), 16'(RST_BAT_UPPER),
                         16'(RST_BAT_RECHARGE), 16'd0);
         end else begin
            rech  = $urandom_range(3000, 50);
            upper = rech + $urandom_range(400, 0);
            stop  = upper + $urandom_range(400, 2);
            if (stop > 4095) stop = 4095;
            low   = $urandom_range(2500, 0);
            program_regs({4'($urandom_range(15)), 12'(low)},
                         {4'($urandom_range(15)), 12'(stop)},
                         {4'($urandom_range(15)), 12'(upper)},
                         {4'($urandom_range(15)), 12'(rech)},
                         16'($urandom_range(12, 0)));
         end
         seg_items = $urandom_range(175, 155);
         for (int n = 0; n < seg_items; n++) begin
            t.power = ($urandom_range(99) >= 4);
            t.valve = ($urandom_range(99) < 7);
            if ($urandom_range(99) < 10) t.supply = 12'($urandom_range(4095));
            else t.supply = 12'($urandom_range(4095, sb.supply_low));
            t.battery = pick_battery();
            send_tick(t);
         end
      end

      // drain and let any stray result show
      settle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

/* sim.f */
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_csr.sv
hw/rtl/bcs_core.sv
hw/rtl/battery_charge_supervisor.sv
test/tb_battery_charge_supervisor.sv
